[hw/rtl/grid_astar_route_search_assert.svh]
// assertion macros for the route search block
`ifndef GRID_ASTAR_ROUTE_SEARCH_ASSERT_SVH
`define GRID_ASTAR_ROUTE_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define GARS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked through reset as well
`define GARS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GARS_ASSERT(label, prop, msg)
`define GARS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hw/rtl/gars_pkg.sv]
package gars_pkg;

  localparam int XY_W     = 6;
  localparam int IDX_W    = 12;
  localparam int CELLS    = 4096;
  localparam int CNT_W    = 13;
  localparam int ROUTE_D  = 256;
  localparam int ROUTE_AW = 8;
  localparam int COST_W   = 16;

  localparam logic [CNT_W-1:0]  ROUTE_MAX = 13'd255;
  localparam logic [COST_W-1:0] COST_MAX  = 16'hFFFF;
  localparam logic [16:0] STEP_STRAIGHT   = 17'd10;
  localparam logic [16:0] STEP_DIAG       = 17'd14;

  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_REACHED = 2'd1;
  localparam logic [1:0] STATUS_NEAREST = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // direction offsets, 7 bit two's complement
  function automatic logic [6:0] step_dx(input logic [2:0] d);
    case (d) inside
      3'd1, 3'd2, 3'd3: return 7'h7F;
      3'd5, 3'd6, 3'd7: return 7'd1;
      default:          return 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] step_dy(input logic [2:0] d);
    case (d) inside
      3'd0, 3'd1, 3'd7: return 7'd1;
      3'd3, 3'd4, 3'd5: return 7'h7F;
      default:          return 7'd0;
    endcase
  endfunction

  // distance estimate: 10 * larger axis plus half of 10 * smaller
  function automatic logic [COST_W-1:0] estimate(input logic [XY_W-1:0] x,
                                                 input logic [XY_W-1:0] y,
                                                 input logic [XY_W-1:0] fx,
                                                 input logic [XY_W-1:0] fy);
    logic [XY_W-1:0] ax, ay;
    logic [9:0] dx10, dy10;
    logic [10:0] e;
    ax = (x > fx) ? x - fx : fx - x;
    ay = (y > fy) ? y - fy : fy - y;
    dx10 = {1'b0, ax, 3'b0} + {3'b0, ax, 1'b0};
    dy10 = {1'b0, ay, 3'b0} + {3'b0, ay, 1'b0};
    if (dx10 > dy10) e = {1'b0, dx10} + {2'b0, dy10[9:1]};
    else e = {2'b0, dx10[9:1]} + {1'b0, dy10};
    return {5'b0, e};
  endfunction

  // tile one step back along direction d, wrapping inside the grid
  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] n,
                                                 input logic [2:0] d);
    logic [6:0] ox, oy;
    ox = step_dx(d);
    oy = step_dy(d);
    return {n[11:6] - oy[5:0], n[5:0] - ox[5:0]};
  endfunction

endpackage

[hw/rtl/gars_ram.sv]
module gars_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/grid_astar_route_search.sv]
// throughput: one request at a time; the full node table scan per expansion sets the pace
// reset: synchronous, clears control state, then a pass over all 4096 tiles zeroes the blocked map
//   while no request is taken; configuration writes are taken at all times
module grid_astar_route_search
  import gars_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tile_x, tile_y, blocked, target_x, target_y, point_index, zero fill
  input  logic [39:0] s_axis_tdata,
  // operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // route_length, point_x, point_y, zero fill
  output logic [23:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  typedef enum logic [16:0] {
    ST_RCLR  = 17'h00001,
    ST_IDLE  = 17'h00002,
    ST_MCLR  = 17'h00004,
    ST_INIT  = 17'h00008,
    ST_SCAN  = 17'h00010,
    ST_PICK  = 17'h00020,
    ST_NADDR = 17'h00040,
    ST_NRD   = 17'h00080,
    ST_NEVAL = 17'h00100,
    ST_CLOSE = 17'h00200,
    ST_LRD   = 17'h00400,
    ST_LEVAL = 17'h00800,
    ST_WRD   = 17'h01000,
    ST_WEVAL = 17'h02000,
    ST_RRD   = 17'h04000,
    ST_RGET  = 17'h08000,
    ST_RESP  = 17'h10000
  } state_t;

  state_t state;

  // configuration
  logic [6:0] map_width, map_height;

  // request fields
  logic [1:0]      in_op;
  logic [XY_W-1:0] in_tx, in_ty, in_fx, in_fy;
  logic            in_blk;
  logic [7:0]      in_idx;

  assign in_op  = s_axis_tuser;
  assign in_tx  = s_axis_tdata[5:0];
  assign in_ty  = s_axis_tdata[11:6];
  assign in_blk = s_axis_tdata[12];
  assign in_fx  = s_axis_tdata[18:13];
  assign in_fy  = s_axis_tdata[24:19];
  assign in_idx = s_axis_tdata[32:25];

  // latched request
  logic [XY_W-1:0] sx, sy, fx, fy;
  logic [7:0]      ridx;

  // search state
  logic [CNT_W-1:0]  scnt;      // sweep and scan counter
  logic [IDX_W-1:0]  addr;      // node under access
  logic [IDX_W-1:0]  cur;       // node being expanded
  logic [COST_W-1:0] cur_cost;
  logic [2:0]        dir;
  logic              bvalid;    // best open node of this scan
  logic [16:0]       bf;
  logic [COST_W-1:0] be, bcost;
  logic [IDX_W-1:0]  bidx;
  logic              have_near, reached;
  logic [COST_W-1:0] near_e;
  logic [IDX_W-1:0]  end_idx;
  logic [CNT_W-1:0]  len, pos;
  logic [7:0]        stored_length;

  // result
  logic [1:0]      res_status;
  logic [XY_W-1:0] res_px, res_py;

  // memory ports
  logic              blk_we, blk_wdata, blk_rdata;
  logic [IDX_W-1:0]  blk_waddr;
  logic              mark_we;
  logic [1:0]        mark_wdata, mark_rdata;
  logic [IDX_W-1:0]  mark_waddr, node_raddr;
  logic              cost_we, est_we, par_we;
  logic [COST_W-1:0] cost_wdata, est_wdata, cost_rdata, est_rdata;
  logic [2:0]        par_rdata;
  logic              route_we;
  logic [11:0]       route_rdata;

  // neighbor and scan datapath
  logic [6:0]        nx7, ny7;
  logic [16:0]       nc_sum, f_sum;
  logic [COST_W-1:0] nc;
  logic              tile_blk, upd, better;
  logic [IDX_W-1:0]  si;

  assign si = {sy, sx};
  assign nx7 = {1'b0, cur[5:0]} + step_dx(dir);
  assign ny7 = {1'b0, cur[11:6]} + step_dy(dir);
  assign nc_sum = {1'b0, cur_cost} + (dir[0] ? STEP_DIAG : STEP_STRAIGHT);
  assign nc = nc_sum[16] ? COST_MAX : nc_sum[15:0];
  assign tile_blk = blk_rdata || ({1'b0, addr[5:0]} >= map_width)
                    || ({1'b0, addr[11:6]} >= map_height);
  assign upd = (mark_rdata == MARK_NONE) ? !tile_blk : (cost_rdata > nc);
  assign f_sum = {1'b0, cost_rdata} + {1'b0, est_rdata};
  assign better = (mark_rdata == MARK_OPEN)
                  && (!bvalid || f_sum < bf || (f_sum == bf && est_rdata < be));

  assign node_raddr = (state == ST_SCAN) ? scnt[IDX_W-1:0] : addr;

  always_comb begin
    blk_we     = 1'b0;
    blk_waddr  = scnt[IDX_W-1:0];
    blk_wdata  = 1'b0;
    mark_we    = 1'b0;
    mark_waddr = addr;
    mark_wdata = MARK_OPEN;
    cost_we    = 1'b0;
    cost_wdata = nc;
    est_we     = 1'b0;
    est_wdata  = estimate(addr[5:0], addr[11:6], fx, fy);
    par_we     = 1'b0;
    route_we   = 1'b0;
    unique case (state)
      ST_RCLR: blk_we = 1'b1;
      ST_IDLE: begin
        // tile write lands the cycle the request is taken
        blk_we    = s_axis_tvalid && in_op == OP_WRITE;
        blk_waddr = {in_ty, in_tx};
        blk_wdata = in_blk;
      end
      ST_MCLR: begin
        mark_we    = 1'b1;
        mark_waddr = scnt[IDX_W-1:0];
        mark_wdata = MARK_NONE;
      end
      ST_INIT: begin
        mark_we    = 1'b1;
        cost_we    = 1'b1;
        cost_wdata = '0;
        est_we     = 1'b1;
      end
      ST_NEVAL: begin
        mark_we = upd;
        cost_we = upd;
        par_we  = upd;
        est_we  = upd && mark_rdata == MARK_NONE;
      end
      ST_CLOSE: begin
        mark_we    = 1'b1;
        mark_wdata = MARK_CLOSED;
      end
      ST_WEVAL: route_we = pos < ROUTE_MAX;
      default: ;
    endcase
  end

  gars_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk (
    .clk, .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(addr), .rdata(blk_rdata)
  );

  gars_ram #(.WIDTH(2), .DEPTH(CELLS)) u_mark (
    .clk, .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(node_raddr), .rdata(mark_rdata)
  );

  gars_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost (
    .clk, .we(cost_we), .waddr(addr), .wdata(cost_wdata),
    .raddr(node_raddr), .rdata(cost_rdata)
  );

  gars_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_est (
    .clk, .we(est_we), .waddr(addr), .wdata(est_wdata),
    .raddr(node_raddr), .rdata(est_rdata)
  );

  gars_ram #(.WIDTH(3), .DEPTH(CELLS)) u_par (
    .clk, .we(par_we), .waddr(addr), .wdata(dir),
    .raddr(addr), .rdata(par_rdata)
  );

  // route points as {y, x}
  gars_ram #(.WIDTH(12), .DEPTH(ROUTE_D)) u_route (
    .clk, .we(route_we), .waddr(pos[ROUTE_AW-1:0]), .wdata(addr),
    .raddr(ridx), .rdata(route_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RCLR;
      scnt          <= '0;
      map_width     <= 7'd64;
      map_height    <= 7'd64;
      stored_length <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_WIDTH) map_width <= cfg_data;
        else map_height <= cfg_data;
      end
      // the response state drives valid itself
      if (m_axis_tvalid && m_axis_tready && state != ST_RESP) m_axis_tvalid <= 1'b0;

      unique case (state)
        // blocked map clearing pass after reset
        ST_RCLR: begin
          scnt <= scnt + 1'b1;
          if (scnt == CNT_W'(CELLS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            sx   <= in_tx;
            sy   <= in_ty;
            fx   <= in_fx;
            fy   <= in_fy;
            ridx <= in_idx;
            res_status <= STATUS_DONE;
            res_px <= '0;
            res_py <= '0;
            scnt <= '0;
            if (in_op == OP_SEARCH) begin
              state <= ST_MCLR;
            end else if (in_op == OP_READ && {5'b0, in_idx} < {5'b0, stored_length}
                         && {5'b0, in_idx} < ROUTE_MAX) begin
              state <= ST_RRD;
            end else begin
              state <= ST_RESP;
            end
          end
        end
        // node marks back to unvisited
        ST_MCLR: begin
          scnt <= scnt + 1'b1;
          if (scnt == CNT_W'(CELLS - 1)) begin
            addr  <= si;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          have_near <= 1'b0;
          reached   <= 1'b0;
          scnt      <= '0;
          bvalid    <= 1'b0;
          state     <= ST_SCAN;
        end
        // registered read data belongs to the scan address of the previous cycle
        ST_SCAN: begin
          if (scnt != '0 && better) begin
            bvalid <= 1'b1;
            bf     <= f_sum;
            be     <= est_rdata;
            bcost  <= cost_rdata;
            bidx   <= IDX_W'(scnt - 1'b1);
          end
          scnt <= scnt + 1'b1;
          if (scnt == CNT_W'(CELLS)) state <= ST_PICK;
        end
        ST_PICK: begin
          if (!bvalid) begin
            addr  <= end_idx;
            len   <= CNT_W'(1);
            state <= ST_LRD;
          end else if (bidx == {fy, fx}) begin
            end_idx <= bidx;
            reached <= 1'b1;
            addr    <= bidx;
            len     <= CNT_W'(1);
            state   <= ST_LRD;
          end else begin
            if (!have_near || be < near_e) begin
              end_idx   <= bidx;
              near_e    <= be;
              have_near <= 1'b1;
            end
            cur      <= bidx;
            cur_cost <= bcost;
            dir      <= '0;
            state    <= ST_NADDR;
          end
        end
        ST_NADDR: begin
          if (nx7[6] || ny7[6]) begin
            // neighbor off the grid
            if (dir == 3'd7) begin
              addr  <= cur;
              state <= ST_CLOSE;
            end else begin
              dir <= dir + 1'b1;
            end
          end else begin
            addr  <= {ny7[5:0], nx7[5:0]};
            state <= ST_NRD;
          end
        end
        ST_NRD: state <= ST_NEVAL;
        ST_NEVAL: begin
          if (dir == 3'd7) begin
            addr  <= cur;
            state <= ST_CLOSE;
          end else begin
            dir   <= dir + 1'b1;
            state <= ST_NADDR;
          end
        end
        ST_CLOSE: begin
          scnt   <= '0;
          bvalid <= 1'b0;
          state  <= ST_SCAN;
        end
        // first parent walk counts the route points
        ST_LRD: state <= ST_LEVAL;
        ST_LEVAL: begin
          if (addr == si || len == CNT_W'(CELLS)) begin
            addr  <= end_idx;
            pos   <= len - 1'b1;
            state <= ST_WRD;
          end else begin
            addr  <= parent_of(addr, par_rdata);
            len   <= len + 1'b1;
            state <= ST_LRD;
          end
        end
        // second walk stores points from the end backward
        ST_WRD: state <= ST_WEVAL;
        ST_WEVAL: begin
          if (pos == '0) begin
            stored_length <= (len < ROUTE_MAX) ? len[7:0] : ROUTE_MAX[7:0];
            res_status    <= reached ? STATUS_REACHED : STATUS_NEAREST;
            state         <= ST_RESP;
          end else begin
            if (addr != si) addr <= parent_of(addr, par_rdata);
            pos   <= pos - 1'b1;
            state <= ST_WRD;
          end
        end
        ST_RRD: state <= ST_RGET;
        ST_RGET: begin
          res_px <= route_rdata[5:0];
          res_py <= route_rdata[11:6];
          state  <= ST_RESP;
        end
        ST_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {4'b0, res_py, res_px, stored_length};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "grid_astar_route_search_assert.svh"

  // no request is taken while the blocked map is being cleared
  `GARS_ASSERT_ALWAYS(a_rst_busy, rst |=> !s_axis_tready, "request taken during reset clear")
  // a neighbor update never targets the node being expanded
  `GARS_ASSERT(a_nb_self, (state == ST_NEVAL) |-> (addr != cur), "neighbor equals current node")
  // a search answer always leaves at least one route point
  `GARS_ASSERT(a_route_len, (m_axis_tvalid && m_axis_tuser != STATUS_DONE) |-> (m_axis_tdata[7:0] != 8'd0), "search answered with empty route")
  // the table scan never runs past the end of the table
  `GARS_ASSERT(a_scan_range, (state == ST_SCAN) |-> (scnt <= CNT_W'(CELLS)), "scan counter overrun")

endmodule
